// ===== design/mie_pkg.sv =====
`default_nettype none

package mie_pkg;

  // Controller states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_START  = 6'b000010,
    ST_DIV    = 6'b000100,
    ST_UPDATE = 6'b001000,
    ST_FINISH = 6'b010000,
    ST_SPARE  = 6'b100000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture a new operand pair
    logic div_start;  // set up one long division
    logic div_step;   // one quotient bit
    logic update;     // fold quotient into remainders and coefficients
    logic finish;     // form the reduced coefficient into the output register
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic r_zero;     // current divisor is zero
    logic div_last;   // division on its final bit
  } sts_t;

endpackage

`default_nettype wire

// ===== design/mie_dpath.sv =====
`default_nettype none

module mie_dpath #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire mie_pkg::ctl_t         cmd,
  output mie_pkg::sts_t              sts,
  input  wire logic [DATA_WIDTH-1:0] value,
  input  wire logic [DATA_WIDTH-1:0] modulus,
  output logic      [DATA_WIDTH-1:0] inverse
);

  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] r_old;   // dividend of the next step
  logic [DATA_WIDTH-1:0] r;       // divisor of the next step
  logic [DATA_WIDTH-1:0] s_old;   // coefficient magnitudes, signs alternate
  logic [DATA_WIDTH-1:0] s;
  logic [DATA_WIDTH-1:0] m;
  logic [DATA_WIDTH-1:0] dq;      // dividend bits shifting out, quotient bits in
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] acc;     // running quotient * s
  logic [CNT_W-1:0]      cnt;
  logic                  parity;  // set: s_old is negative

  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   diff;
  logic                  fits;
  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH-1:0] acc_next;
  logic [DATA_WIDTH-1:0] inverse_next;

  // restoring division, one bit per cycle; the product q*s builds MSB first
  assign rem_sh   = {rem, dq[DATA_WIDTH-1]};
  assign diff     = rem_sh - {1'b0, r};
  assign fits     = (rem_sh >= {1'b0, r});
  assign rem_next = fits ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
  assign acc_next = {acc[DATA_WIDTH-2:0], 1'b0} + (fits ? s : '0);

  always_comb begin
    if (m == '0) begin
      inverse_next = '0;
    end else if (parity && (s_old != '0)) begin
      inverse_next = m - s_old;
    end else begin
      inverse_next = s_old;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_old  <= value;
      r      <= modulus;
      m      <= modulus;
      s_old  <= DATA_WIDTH'(1);
      s      <= '0;
      parity <= 1'b0;
    end else if (cmd.div_start) begin
      dq  <= r_old;
      rem <= '0;
      acc <= '0;
      cnt <= CNT_W'(DATA_WIDTH - 1);
    end else if (cmd.div_step) begin
      dq  <= {dq[DATA_WIDTH-2:0], fits};
      rem <= rem_next;
      acc <= acc_next;
      cnt <= cnt - 1'b1;
    end else if (cmd.update) begin
      r_old  <= r;
      r      <= rem;
      s_old  <= s;
      s      <= s_old + acc;
      parity <= ~parity;
    end else if (cmd.finish) begin
      inverse <= inverse_next;
    end
  end

  assign sts.r_zero   = (r == '0);
  assign sts.div_last = (cnt == '0);

endmodule

`default_nettype wire

// ===== design/mie_ctrl.sv =====
`default_nettype none

module mie_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire mie_pkg::sts_t sts,
  output mie_pkg::ctl_t      cmd
);

  mie_pkg::state_t state;
  mie_pkg::state_t state_next;

  assign in_stall = (state != mie_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      mie_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = mie_pkg::ST_START;
        end
      end
      mie_pkg::ST_START: begin
        if (sts.r_zero) begin
          state_next = mie_pkg::ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = mie_pkg::ST_DIV;
        end
      end
      mie_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = mie_pkg::ST_UPDATE;
        end
      end
      mie_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = mie_pkg::ST_START;
      end
      mie_pkg::ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid || !out_stall) begin
          cmd.finish = 1'b1;
          state_next = mie_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mie_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mie_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/modular_inverse_ext_euclid.sv =====
// Modular inverse by the extended Euclidean algorithm.
//
// Input channel: in_valid / in_stall carry one beat of {value, modulus}.
// Output channel: out_valid / out_stall carry one beat of inverse, the
// Bezout coefficient of value reduced into 0..modulus-1 (the inverse when
// gcd(value, modulus) is 1; no flag otherwise). Modulus zero gives 0.
//
// Timing: one item at a time; the next beat is taken only once the result
// has gone into the output register. Each Euclid step is a bit-serial
// restoring division of DATA_WIDTH quotient bits, with a setup state before
// it and an update state after it. For 32-bit operands the number of
// quotient steps is at most 46. The product q*s is accumulated alongside
// the serial division, with alternating coefficient signs.
//
// Output is registered and holds its beat while out_stall is high; a
// later result waits in the controller, with in_stall high, until the
// register frees. Reset (synchronous, rst) returns the controller to idle
// and drops out_valid; nothing else persists between items.

`default_nettype none

module modular_inverse_ext_euclid #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [DATA_WIDTH-1:0] value,
  input  wire logic [DATA_WIDTH-1:0] modulus,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [DATA_WIDTH-1:0] inverse
);

  mie_pkg::ctl_t cmd;
  mie_pkg::sts_t sts;

  mie_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mie_dpath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk     (clk),
    .cmd     (cmd),
    .sts     (sts),
    .value   (value),
    .modulus (modulus),
    .inverse (inverse)
  );

  // an accepted beat keeps the block busy for at least the next cycle
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted but block not busy");

  // a new result only appears at the end of a computation
  a_result_from_work : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in flight");

  // the datapath never gets two commands in one cycle
  a_one_command : assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// ===== tb/sv/modular_inverse_ext_euclid_test.sv =====
`timescale 1ns / 1ps

module modular_inverse_ext_euclid_test;

  localparam int W            = 32;
  localparam int RANDOM_BEATS = 370;
  localparam int CALM_BEATS   = 50;    // last random beats run with no idling
  localparam int HOLD_AT      = 30;    // random beat at which the long hold-off starts
  localparam int HOLD_CYCLES  = 6000;  // long enough to fill the block and stall its input
  localparam int QUIET_LIMIT  = 40000; // hold-off plus a few worst-case items, several times
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_DEPTH    = 128;

  localparam logic [W-1:0] ALL_ONES = {W{1'b1}};

  // One directed row. Where known is set, the inverse is typed in here;
  // otherwise the predictor supplies it.
  typedef struct packed {
    logic [W-1:0] value;
    logic [W-1:0] modulus;
    logic         known;
    logic [W-1:0] inverse;
  } vector_t;

  localparam int NUM_DIRECTED = 20;

  vector_t directed_rows [NUM_DIRECTED] = '{
    // modulus zero is out of range; the block returns 0
    '{32'd5,           32'd0,           1'b1, 32'd0},
    '{ALL_ONES,        32'd0,           1'b1, 32'd0},
    // modulus one: every residue is 0
    '{ALL_ONES,        32'd1,           1'b1, 32'd0},
    '{32'd0,           32'd1,           1'b1, 32'd0},
    // value zero: coefficient is 0
    '{32'd0,           ALL_ONES,        1'b1, 32'd0},
    // trivial inverses
    '{32'd1,           ALL_ONES,        1'b1, 32'd1},
    '{32'd1,           32'd2,           1'b1, 32'd1},
    '{32'hFFFF_FFFE,   ALL_ONES,        1'b1, 32'hFFFF_FFFE},  // -1 is its own inverse
    '{32'd3,           32'd7,           1'b1, 32'd5},
    // value equal to / above the modulus
    '{ALL_ONES,        ALL_ONES,        1'b0, 32'd0},
    '{ALL_ONES,        32'hFFFF_FFFE,   1'b0, 32'd0},
    '{ALL_ONES,        32'h8000_0000,   1'b0, 32'd0},
    // common factor, no flag
    '{32'd12,          32'd18,          1'b0, 32'd0},
    '{32'h5555_5555,   32'hAAAA_AAAA,   1'b0, 32'd0},
    '{32'hAAAA_AAAA,   32'h5555_5555,   1'b0, 32'd0},
    // consecutive Fibonacci numbers: the longest Euclid chain at this width
    '{32'd2971215073,  32'd1836311903,  1'b0, 32'd0},
    '{32'd1836311903,  32'd2971215073,  1'b0, 32'd0},
    '{32'h8000_0000,   ALL_ONES,        1'b0, 32'd0},
    '{32'd7,           32'h8000_0000,   1'b0, 32'd0},
    '{32'hDEAD_BEEF,   32'hFFFF_FFFB,   1'b0, 32'd0}
  };

  logic         clk;
  logic         rst       = 1'b1;
  logic         in_valid  = 1'b0;
  logic         in_stall;
  logic [W-1:0] value     = '0;
  logic [W-1:0] modulus   = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [W-1:0] inverse;

  // Inverses owed by the block, oldest first.
  logic [W-1:0] inverse_due [$];
  logic [W-1:0] owed;

  int  mismatches = 0;
  int  quiet      = 0;
  bit  calm       = 1'b0;  // set for the tail of the run: no idling on either side
  bit  hold_req   = 1'b0;  // sender asks for the one long receiver hold-off
  bit  hold_taken = 1'b0;

  modular_inverse_ext_euclid #(
    .DATA_WIDTH(W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .value    (value),
    .modulus  (modulus),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .inverse  (inverse)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Predictor: extended Euclid, coefficients carried modulo m. The
  // quotient chain is walked down first, then unwound from x=1, y=0 with
  // x' = y, y' = x - q*y. Operands are below 2^32, so q*y fits in 64 bits.
  function automatic logic [W-1:0] mod_inverse_of(logic [W-1:0] v, logic [W-1:0] m);
    logic [63:0] a, b, r, x, y, q, nx, prod, mm;
    logic [63:0] quo [MAX_DEPTH];
    int          depth;
    if (m == '0) return '0;
    mm    = 64'(m);
    a     = 64'(v);
    b     = mm;
    depth = 0;
    while (b != 0 && depth < MAX_DEPTH) begin
      r          = a % b;
      quo[depth] = a / b;
      depth++;
      a = b;
      b = r;
    end
    x = 64'd1 % mm;
    y = 64'd0;
    while (depth > 0) begin
      depth--;
      q    = quo[depth] % mm;
      prod = (q * y) % mm;
      nx   = y;
      y    = (x >= prod) ? x - prod : x + (mm - prod);
      x    = nx;
    end
    return x[W-1:0];
  endfunction

  task automatic note_mismatch(input string what, input logic [W-1:0] want,
                               input logic [W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  // Offer one beat; the inverse it owes is queued at the edge that takes it.
  // A random gap may come first, unless the run is in its calm tail.
  task automatic offer_beat(input logic [W-1:0] v, input logic [W-1:0] m,
                            input logic [W-1:0] want);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    modulus  <= m;
    do @(posedge clk); while (in_stall !== 1'b0);
    inverse_due.push_back(want);
  endtask

  // Operand mix for the random part. Full-width pairs dominate; the rest
  // aim at short chains, shared factors, long Fibonacci chains, value at
  // or past the modulus, and the tiny moduli.
  task automatic pick_operands(output logic [W-1:0] v, output logic [W-1:0] m);
    int          kind;
    int          f;
    int          k;
    logic [63:0] f0, f1;
    kind = $urandom_range(0, 9);
    case (kind) inside
      [0:3]: begin
        v = $urandom;
        m = $urandom;
      end
      4: begin
        v = $urandom_range(0, 255);
        m = $urandom_range(1, 255);
      end
      5: begin
        f = $urandom_range(2, 1000);
        v = W'($urandom_range(0, ALL_ONES / f) * f);
        m = W'($urandom_range(1, ALL_ONES / f) * f);
      end
      6: begin
        f0 = 64'd0;
        f1 = 64'd1;
        k  = $urandom_range(20, 47);
        repeat (k - 1) {f0, f1} = {f1, f0 + f1};
        if ($urandom_range(0, 1) == 0) begin
          v = f1[W-1:0];
          m = f0[W-1:0];
        end else begin
          v = f0[W-1:0];
          m = f1[W-1:0];
        end
      end
      7: begin
        m = $urandom >> $urandom_range(0, 31);
        v = $urandom;
      end
      8: begin
        m = $urandom;
        if (m == '0) m = 1;
        case ($urandom_range(0, 5))
          0:       v = '0;
          1:       v = 1;
          2:       v = ALL_ONES;
          3:       v = m - 1;
          4:       v = m;
          default: v = m + 1;
        endcase
      end
      default: begin
        v = $urandom;
        case ($urandom_range(0, 2))
          0:       m = 1;
          1:       m = 2;
          default: m = ALL_ONES;
        endcase
      end
    endcase
    if (m == '0) m = 1;  // random part stays inside the legal range
  endtask

  // Receiver: random stall bursts and free-running stretches, one long
  // hold-off on request, and no stalls at all in the calm tail.
  initial begin
    int span;
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end else if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        span = $urandom_range(1, 7);
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
      end else begin
        span = $urandom_range(1, 30);
        out_stall <= 1'b0;
        repeat (span) @(posedge clk);
      end
    end
  end

  // Result check: every accepted beat against the oldest owed inverse.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (inverse_due.size() == 0) begin
        note_mismatch("inverse with nothing outstanding", '0, inverse);
      end else begin
        owed = inverse_due.pop_front();
        if (inverse !== owed) note_mismatch("inverse", owed, inverse);
      end
    end
  end

  // Watchdog: cycles in a row with no beat on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("modular_inverse_ext_euclid_test: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [W-1:0] v, m;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: typed-in inverse where obvious, predictor otherwise.
    foreach (directed_rows[i]) begin
      v = directed_rows[i].value;
      m = directed_rows[i].modulus;
      offer_beat(v, m, directed_rows[i].known ? directed_rows[i].inverse
                                              : mod_inverse_of(v, m));
    end

    // Random part. The hold-off is only requested; the sender keeps
    // offering beats so the block backs up and stalls its input.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == HOLD_AT) hold_req = 1'b1;
      if (n == RANDOM_BEATS - CALM_BEATS) calm = 1'b1;
      pick_operands(v, m);
      offer_beat(v, m, mod_inverse_of(v, m));
    end
    in_valid <= 1'b0;

    // Drain, then give the block a little longer to show any stray beat.
    while (inverse_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("modular_inverse_ext_euclid_test: clean");
    end else begin
      $display("modular_inverse_ext_euclid_test: errors");
    end
    $finish;
  end

endmodule
